/* sv/fpsm_pkg.sv */
// Shared types, constants and arithmetic helpers for the five-point stencil
// matrix-vector block. No dependencies.
package fpsm_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned PROD_W    = 2 * DATA_W - FRAC_W;
  localparam int unsigned SUM_W     = 50;
  localparam int unsigned SIDE_W    = 7;
  localparam int unsigned ROWS_W    = 13;
  localparam int unsigned ROW_IDX_W = 12;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd8;
  localparam logic [SIDE_W-1:0] SIDE_MIN   = 7'd2;

  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] b_start;
    logic signed [DATA_W-1:0] coef_center;
    logic signed [DATA_W-1:0] coef_north;
    logic signed [DATA_W-1:0] coef_south;
    logic signed [DATA_W-1:0] coef_west;
    logic signed [DATA_W-1:0] coef_east;
  } item_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0]     row_index;
    logic signed [DATA_W-1:0] b_value;
    logic                     saturated;
    logic                     last;
  } result_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     clipped;
  } sat_t;

  // Q16.16 product, low fraction bits dropped (floor).
  function automatic logic signed [PROD_W-1:0] qmul(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic signed [2*DATA_W-1:0] p;
    p = a * b;
    return p[2*DATA_W-1:FRAC_W];
  endfunction

  // Clip a wide sum to the signed 32-bit range.
  function automatic sat_t saturate(input logic signed [SUM_W-1:0] s);
    sat_t                     r;
    logic [SUM_W-DATA_W:0]    hi;
    hi = s[SUM_W-1:DATA_W-1];
    if (hi == '0 || hi == '1) begin
      r.value   = s[DATA_W-1:0];
      r.clipped = 1'b0;
    end else if (s[SUM_W-1]) begin
      r.value   = {1'b1, {(DATA_W-1){1'b0}}};
      r.clipped = 1'b1;
    end else begin
      r.value   = {1'b0, {(DATA_W-1){1'b1}}};
      r.clipped = 1'b1;
    end
    return r;
  endfunction

endpackage

/* sv/fpsm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
module fpsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/five_point_stencil_matvec.sv */
// Five-point stencil matrix-vector multiply: one grid row per transfer, row r
// emitted when row r+n arrives, n flush transfers drain the last rows.
// A result passes the stage 1, 2, 3 and 4 registers and then the output
// register after the transfer that causes it. Throughput: one item per cycle;
// only output back-pressure stalls the input.
// Reset (rst, synchronous): grid_side to 8, counters and valid bits cleared;
// RAM is not cleared; every entry a result uses is written earlier in a grid.
module five_point_stencil_matvec
  import fpsm_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic              clk,
  input  logic              rst,
  // configuration: grid side
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIDE_W-1:0] cfg_data,
  // input items
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  // results
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result
);

  localparam int unsigned COL_W = $clog2(MAX_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [SIDE_W-1:0]   grid_side;
  logic [SIDE_W-1:0]   side;
  logic [SIDE_W-1:0]   side_m1;
  logic [2*SIDE_W-1:0] dim;
  logic                cfg_xfer;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= SIDE_RESET;
    end else if (cfg_xfer) begin
      grid_side <= cfg_data;
    end
  end

  // out-of-range sides are clamped
  always_comb begin
    priority if (grid_side < SIDE_MIN) begin
      side = SIDE_MIN;
    end else if (grid_side > SIDE_MAX) begin
      side = SIDE_MAX;
    end else begin
      side = grid_side;
    end
  end

  assign side_m1 = side - SIDE_W'(1);
  assign dim     = side * side;

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipeline moves together unless the output register
  // holds a result that is being stalled.
  // ---------------------------------------------------------------------------
  logic adv;
  logic accept;

  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;
  assign accept     = item_valid && adv;

  // ---------------------------------------------------------------------------
  // Stage 0: item decode against the row counters
  // ---------------------------------------------------------------------------
  logic [ROWS_W-1:0]        rows_received;
  logic [ROWS_W-1:0]        rows_emitted;
  logic [COL_W-1:0]         recv_col;     // rows_received mod n
  logic [COL_W-1:0]         emit_col;     // rows_emitted mod n
  logic signed [DATA_W-1:0] prev_east;
  logic signed [DATA_W-1:0] prev_x;

  logic              data_ok;
  logic              flush_ok;
  logic              emit0;
  logic              recv_wrap;
  logic              emit_wrap;
  logic              flush_final;
  logic [ROWS_W-1:0] data_row;

  assign data_ok     = (item.kind == KIND_DATA) && ({1'b0, rows_received} < dim);
  // a flush counts only once the whole grid is in and rows remain
  assign flush_ok    = (item.kind == KIND_FLUSH) && ({1'b0, rows_received} == dim)
                       && ({1'b0, rows_emitted} < dim);
  assign emit0       = rows_received >= ROWS_W'(side);
  assign recv_wrap   = SIDE_W'(recv_col) == side_m1;
  assign emit_wrap   = SIDE_W'(emit_col) == side_m1;
  assign flush_final = {1'b0, rows_emitted} == (dim - (2*SIDE_W)'(1));
  assign data_row    = rows_received - ROWS_W'(side);

  always_ff @(posedge clk) begin
    if (rst || cfg_xfer) begin
      rows_received <= '0;
      rows_emitted  <= '0;
      recv_col      <= '0;
      emit_col      <= '0;
    end else if (accept && data_ok) begin
      rows_received <= rows_received + ROWS_W'(1);
      recv_col      <= recv_wrap ? '0 : recv_col + COL_W'(1);
      if (emit0) begin
        rows_emitted <= rows_emitted + ROWS_W'(1);
        emit_col     <= emit_wrap ? '0 : emit_col + COL_W'(1);
      end
    end else if (accept && flush_ok) begin
      if (flush_final) begin
        // grid done: next data item starts a new grid
        rows_received <= '0;
        rows_emitted  <= '0;
        recv_col      <= '0;
        emit_col      <= '0;
      end else begin
        rows_emitted <= rows_emitted + ROWS_W'(1);
        emit_col     <= emit_wrap ? '0 : emit_col + COL_W'(1);
      end
    end
  end

  // west neighbour x and east coefficient of the row before
  always_ff @(posedge clk) begin
    if (accept && data_ok) begin
      prev_east <= item.coef_east;
      prev_x    <= item.x_value;
    end
  end

  // x / south-coefficient window: slot col holds row r-n until row r replaces it
  logic [2*DATA_W-1:0]      xs_rdata;
  logic signed [DATA_W-1:0] xs_x;
  logic signed [DATA_W-1:0] xs_south;

  fpsm_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_SIDE)
  ) u_xs_ram (
    .clk   (clk),
    .we    (accept && data_ok),
    .waddr (recv_col),
    .wdata ({item.x_value, item.coef_south}),
    .re    (adv),
    .raddr (recv_col),
    .rdata (xs_rdata)
  );

  assign xs_x     = xs_rdata[2*DATA_W-1:DATA_W];
  assign xs_south = xs_rdata[DATA_W-1:0];

  // ---------------------------------------------------------------------------
  // Stage 1: products (one multiplier per stencil term)
  // ---------------------------------------------------------------------------
  logic                     s1_valid;
  logic                     s1_data;
  logic                     s1_emit;
  logic                     s1_col_nz;
  logic [COL_W-1:0]         s1_col;
  logic [ROW_IDX_W-1:0]     s1_row;
  logic                     s1_last;
  logic signed [DATA_W-1:0] s1_x;
  logic signed [DATA_W-1:0] s1_b;
  logic signed [DATA_W-1:0] s1_c;
  logic signed [DATA_W-1:0] s1_n;
  logic signed [DATA_W-1:0] s1_w;
  logic signed [DATA_W-1:0] s1_e_prev;
  logic signed [DATA_W-1:0] s1_x_prev;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept && (data_ok || flush_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_data   <= data_ok;
      s1_emit   <= data_ok ? emit0 : 1'b1;
      s1_col_nz <= recv_col != '0;
      s1_col    <= data_ok ? recv_col : emit_col;
      s1_row    <= data_ok ? data_row[ROW_IDX_W-1:0] : rows_emitted[ROW_IDX_W-1:0];
      s1_last   <= flush_ok && flush_final;
      s1_x      <= item.x_value;
      s1_b      <= item.b_start;
      s1_c      <= item.coef_center;
      s1_n      <= item.coef_north;
      s1_w      <= item.coef_west;
      s1_e_prev <= prev_east;
      s1_x_prev <= prev_x;
    end
  end

  logic signed [PROD_W-1:0] p_center;
  logic signed [PROD_W-1:0] p_north;
  logic signed [PROD_W-1:0] p_west;
  logic signed [PROD_W-1:0] p_east;
  logic signed [PROD_W-1:0] p_south;

  // absent neighbours contribute zero
  assign p_center = qmul(s1_c, s1_x);
  assign p_north  = s1_emit ? qmul(s1_n, xs_x) : '0;
  assign p_west   = s1_col_nz ? qmul(s1_w, s1_x_prev) : '0;
  assign p_east   = s1_col_nz ? qmul(s1_e_prev, s1_x) : '0;
  assign p_south  = qmul(xs_south, s1_x);

  // ---------------------------------------------------------------------------
  // Stage 2: partial sums
  // ---------------------------------------------------------------------------
  logic                     s2_valid;
  logic                     s2_data;
  logic                     s2_emit;
  logic [COL_W-1:0]         s2_col;
  logic [ROW_IDX_W-1:0]     s2_row;
  logic                     s2_last;
  logic signed [DATA_W-1:0] s2_b;
  logic signed [PROD_W-1:0] s2_p_center;
  logic signed [PROD_W-1:0] s2_p_north;
  logic signed [PROD_W-1:0] s2_p_west;
  logic signed [PROD_W-1:0] s2_p_east;
  logic signed [PROD_W-1:0] s2_p_south;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_data     <= s1_data;
      s2_emit     <= s1_emit;
      s2_col      <= s1_col;
      s2_row      <= s1_row;
      s2_last     <= s1_last;
      s2_b        <= s1_b;
      s2_p_center <= p_center;
      s2_p_north  <= p_north;
      s2_p_west   <= p_west;
      s2_p_east   <= p_east;
      s2_p_south  <= p_south;
    end
  end

  logic signed [SUM_W-1:0] sum_a;
  logic signed [SUM_W-1:0] sum_b;

  assign sum_a = SUM_W'(s2_b) + SUM_W'(s2_p_center);
  assign sum_b = SUM_W'(s2_p_north) + SUM_W'(s2_p_west);

  // ---------------------------------------------------------------------------
  // Stage 3: row sum, write-back of the previous row, pending-sum read
  // ---------------------------------------------------------------------------
  logic                     s3_valid;
  logic                     s3_data;
  logic                     s3_emit;
  logic [COL_W-1:0]         s3_col;
  logic [ROW_IDX_W-1:0]     s3_row;
  logic                     s3_last;
  logic signed [SUM_W-1:0]  s3_sum_a;
  logic signed [SUM_W-1:0]  s3_sum_b;
  logic signed [PROD_W-1:0] s3_p_east;
  logic signed [PROD_W-1:0] s3_p_south;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_data    <= s2_data;
      s3_emit    <= s2_emit;
      s3_col     <= s2_col;
      s3_row     <= s2_row;
      s3_last    <= s2_last;
      s3_sum_a   <= sum_a;
      s3_sum_b   <= sum_b;
      s3_p_east  <= s2_p_east;
      s3_p_south <= s2_p_south;
    end
  end

  // The newest row's sum waits here for its east term, which arrives with the
  // next row; it is written to the pending RAM when that next item passes.
  logic                    held_valid;
  logic [COL_W-1:0]        held_col;
  logic signed [SUM_W-1:0] held_sum;
  logic signed [SUM_W-1:0] row_acc;
  logic signed [SUM_W-1:0] pend_wdata;
  logic                    pend_we;

  assign row_acc    = s3_sum_a + s3_sum_b;
  assign pend_wdata = held_sum + (s3_data ? SUM_W'(s3_p_east) : SUM_W'(0));
  assign pend_we    = adv && s3_valid && held_valid;

  always_ff @(posedge clk) begin
    if (rst || cfg_xfer) begin
      held_valid <= 1'b0;
    end else if (adv && s3_valid) begin
      held_valid <= s3_data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid && s3_data) begin
      held_sum <= row_acc;
      held_col <= s3_col;
    end
  end

  logic [SUM_W-1:0] pend_rdata;

  fpsm_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_SIDE)
  ) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (held_col),
    .wdata (pend_wdata),
    .re    (adv),
    .raddr (s3_col),
    .rdata (pend_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 4: add south term, saturate, into the output register
  // ---------------------------------------------------------------------------
  logic                     s4_valid;
  logic                     s4_data;
  logic                     s4_emit;
  logic [ROW_IDX_W-1:0]     s4_row;
  logic                     s4_last;
  logic signed [PROD_W-1:0] s4_p_south;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_data    <= s3_data;
      s4_emit    <= s3_emit;
      s4_row     <= s3_row;
      s4_last    <= s3_last;
      s4_p_south <= s3_p_south;
    end
  end

  logic signed [SUM_W-1:0] row_done;
  sat_t                    row_sat;

  // flush rows have no south neighbour, so no south term is added
  assign row_done = $signed(pend_rdata) + (s4_data ? SUM_W'(s4_p_south) : SUM_W'(0));
  assign row_sat  = saturate(row_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s4_valid && s4_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.row_index <= s4_row;
      result.b_value   <= row_sat.value;
      result.saturated <= row_sat.clipped;
      result.last      <= s4_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_emit_behind_recv: assert property (@(posedge clk) disable iff (rst)
    rows_emitted <= rows_received)
    else $error("more rows emitted than received");

  a_recv_col_range: assert property (@(posedge clk) disable iff (rst)
    SIDE_W'(recv_col) < side)
    else $error("receive column outside grid side");

  a_pend_no_collide: assert property (@(posedge clk) disable iff (rst)
    pend_we |-> (held_col != s3_col))
    else $error("pending write and read hit the same slot");

  a_held_before_emit: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_data && s3_emit) |-> held_valid)
    else $error("emitting data row without a held previous row");

endmodule
